// File: hw/rtl/ffba_pkg.sv
package ffba_pkg;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_NULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // configuration register indexes
  localparam int          CFG_IDX_W     = 2;
  localparam logic [1:0]  CFG_HEAP_BASE  = 2'd0;
  localparam logic [1:0]  CFG_HEAP_BYTES = 2'd1;

  localparam logic [31:0] HEAP_BYTES_RST = 32'd65536;

  typedef struct packed {
    logic        kind;
    logic [31:0] request_bytes;
    logic [31:0] block_address;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] payload;
    logic        free;
  } entry_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_SH_RD,
    S_SH_WR,
    S_SPL_NEW,
    S_GRANT,
    S_F_RD,
    S_F_CHK,
    S_L_RD,
    S_L_CHK,
    S_R_RD,
    S_R_CHK,
    S_RM_RD,
    S_RM_WR,
    S_OUT
  } ffba_state_t;

endpackage

// File: hw/rtl/ffba_table.sv
module ffba_table
  import ffba_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/first_fit_block_allocator_unit.sv
// Channel  Dir  Handshake              Word
// in_      in   in_valid / in_stall    in_word  (kind, request_bytes, block_address)
// out_     out  out_valid / out_stall  out_word (result_address, status)
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word at a time through a single-port-read block table, whose read
// latency sets the pace. An allocate scans for the first fit and, on a split,
// shifts later entries up and writes the new free entry before the grant; a
// free scans for the block and merges it with free neighbours, moving entries down.
// Reset and a heap base or heap bytes write re-initialise the table (entry 0).
// A finished result waits in the output register; the next word is taken
// while it waits and only the hand-over to the output register stalls.
module first_fit_block_allocator_unit
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int AW    = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
  localparam logic [31:0]      HDR32 = 32'(HEADER_BYTES);
  localparam logic [33:0]      HDR34 = 34'(HEADER_BYTES);

  ffba_state_t state_r, state_nxt;

  logic [31:0]      base_r, bytes_r;
  logic [CNT_W-1:0] count_r, idx_r, k_r;
  logic [32:0]      need_r;
  entry_t           cur_r;
  logic             do_split_r, after_left_r;
  logic [31:0]      res_addr_r;
  logic [1:0]       res_st_r;
  logic             out_valid_r;
  out_word_t        out_word_r;
  logic [31:0]      in_word_r_addr;

  // table port
  logic             wr_en;
  logic [CNT_W-1:0] wr_idx, rd_idx;
  entry_t           wr_data, rd_data;

  ffba_table #(.DEPTH(MAX_BLOCKS), .AW(AW)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // handshakes
  logic cfg_fire, cfg_hit, in_fire, out_free;
  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && (cfg_index == CFG_HEAP_BASE || cfg_index == CFG_HEAP_BYTES);
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // shared arithmetic on the entry just read
  logic [CNT_W-1:0] idx_p1, idx_m1, k_p1, k_m1;
  logic [32:0]      need_in;
  logic             fit, split_ok, addr_hit;
  logic [33:0]      msum;
  logic [31:0]      mpay, init_pay;

  assign idx_p1   = idx_r + ONE_C;
  assign idx_m1   = idx_r - ONE_C;
  assign k_p1     = k_r + ONE_C;
  assign k_m1     = k_r - ONE_C;
  assign need_in  = ({1'b0, in_word.request_bytes} + 33'd3) & ~33'd3;
  assign fit      = rd_data.free && ({1'b0, rd_data.payload} >= need_r);
  assign split_ok = ({2'b0, rd_data.payload} >= ({1'b0, need_r} + HDR34 + 34'd4))
                    && (count_r < MAX_C);
  assign addr_hit = (base_r + rd_data.offset + HDR32) == in_word_r_addr;
  // merged payload saturates at all ones
  assign msum     = {2'b0, rd_data.payload} + HDR34 + {2'b0, cur_r.payload};
  assign mpay     = (msum[33:32] != 2'b0) ? 32'hFFFF_FFFF : msum[31:0];
  assign init_pay = (bytes_r >= HDR32) ? (bytes_r - HDR32) : 32'd0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:  state_nxt = S_IDLE;
      S_IDLE: begin
        if (cfg_hit) begin
          state_nxt = S_INIT;
        end else if (in_fire) begin
          if (in_word.kind == KIND_ALLOC) begin
            state_nxt = S_A_RD;
          end else if (in_word.block_address == 32'd0) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_F_RD;
          end
        end
      end
      S_A_RD:    state_nxt = (idx_r == count_r) ? S_OUT : S_A_CHK;
      S_A_CHK:   state_nxt = fit ? (split_ok ? S_SH_RD : S_GRANT) : S_A_RD;
      S_SH_RD:   state_nxt = (k_r > idx_p1) ? S_SH_WR : S_SPL_NEW;
      S_SH_WR:   state_nxt = S_SH_RD;
      S_SPL_NEW: state_nxt = S_GRANT;
      S_GRANT:   state_nxt = S_OUT;
      S_F_RD:    state_nxt = (idx_r == count_r) ? S_OUT : S_F_CHK;
      S_F_CHK: begin
        if (addr_hit) begin
          state_nxt = (idx_r != '0) ? S_L_RD : S_R_RD;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_L_RD:    state_nxt = S_L_CHK;
      S_L_CHK:   state_nxt = rd_data.free ? S_RM_RD : S_R_RD;
      S_R_RD:    state_nxt = (idx_p1 >= count_r) ? S_OUT : S_R_CHK;
      S_R_CHK:   state_nxt = rd_data.free ? S_RM_RD : S_OUT;
      S_RM_RD: begin
        if (k_p1 >= count_r) begin
          state_nxt = after_left_r ? S_R_RD : S_OUT;
        end else begin
          state_nxt = S_RM_WR;
        end
      end
      S_RM_WR:   state_nxt = S_RM_RD;
      S_OUT:     state_nxt = out_free ? S_IDLE : S_OUT;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // table port drive
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = idx_r;
    wr_data = cur_r;
    rd_idx  = idx_r;
    unique case (state_r)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_idx  = '0;
        wr_data = '{offset: 32'd0, payload: init_pay, free: 1'b1};
      end
      S_SH_RD:   rd_idx = k_m1;
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_idx  = k_r;
        wr_data = rd_data;
      end
      S_SPL_NEW: begin
        wr_en   = 1'b1;
        wr_idx  = idx_p1;
        wr_data = '{offset:  cur_r.offset + HDR32 + need_r[31:0],
                    payload: cur_r.payload - need_r[31:0] - HDR32,
                    free:    1'b1};
      end
      S_GRANT: begin
        wr_en   = 1'b1;
        wr_data = '{offset:  cur_r.offset,
                    payload: do_split_r ? need_r[31:0] : cur_r.payload,
                    free:    1'b0};
      end
      S_F_CHK: begin
        wr_en   = addr_hit;
        wr_data = '{offset: rd_data.offset, payload: rd_data.payload, free: 1'b1};
      end
      S_L_RD:    rd_idx = idx_m1;
      S_L_CHK: begin
        wr_en   = rd_data.free;
        wr_idx  = idx_m1;
        wr_data = '{offset: rd_data.offset, payload: mpay, free: 1'b1};
      end
      S_R_RD:    rd_idx = idx_p1;
      S_R_CHK: begin
        wr_en   = rd_data.free;
        wr_data = '{offset: cur_r.offset, payload: mpay, free: 1'b1};
      end
      S_RM_RD:   rd_idx = k_p1;
      S_RM_WR: begin
        wr_en   = 1'b1;
        wr_idx  = k_r;
        wr_data = rd_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      base_r      <= 32'd0;
      bytes_r     <= HEAP_BYTES_RST;
      count_r     <= ONE_C;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_hit) begin
        if (cfg_index == CFG_HEAP_BASE) begin
          base_r <= cfg_data;
        end else begin
          bytes_r <= cfg_data;
        end
      end
      unique case (state_r)
        S_INIT:    count_r <= ONE_C;
        S_SPL_NEW: count_r <= count_r + ONE_C;
        S_RM_RD: begin
          if (k_p1 >= count_r) begin
            count_r <= count_r - ONE_C;
          end
        end
        default: count_r <= count_r;
      endcase
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_word_r <= '{result_address: res_addr_r, status: res_st_r};
    end
    unique case (state_r)
      S_IDLE: begin
        idx_r          <= '0;
        need_r         <= need_in;
        in_word_r_addr <= in_word.block_address;
        res_addr_r     <= 32'd0;
        res_st_r       <= (in_word.kind == KIND_FREE && in_word.block_address == 32'd0)
                          ? ST_NULL : ST_DONE;
      end
      S_A_RD: begin
        if (idx_r == count_r) begin
          res_st_r <= ST_NOFIT;
        end
      end
      S_A_CHK: begin
        if (fit) begin
          cur_r      <= rd_data;
          do_split_r <= split_ok;
          k_r        <= count_r;
        end else begin
          idx_r <= idx_p1;
        end
      end
      S_SH_WR:   k_r <= k_m1;
      S_GRANT:   res_addr_r <= base_r + cur_r.offset + HDR32;
      S_F_RD: begin
        if (idx_r == count_r) begin
          res_st_r <= ST_UNKNOWN;
        end
      end
      S_F_CHK: begin
        if (addr_hit) begin
          cur_r <= '{offset: rd_data.offset, payload: rd_data.payload, free: 1'b1};
        end else begin
          idx_r <= idx_p1;
        end
      end
      S_L_CHK: begin
        if (rd_data.free) begin
          cur_r        <= '{offset: rd_data.offset, payload: mpay, free: 1'b1};
          k_r          <= idx_r;
          idx_r        <= idx_m1;
          after_left_r <= 1'b1;
        end
      end
      S_R_CHK: begin
        k_r          <= idx_p1;
        after_left_r <= 1'b0;
      end
      S_RM_WR:   k_r <= k_p1;
      default: begin
        k_r <= k_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  // table never empty and never beyond its size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= MAX_C))
    else $error("block count out of range");

  // scan index stays within the table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_INIT) |-> (idx_r <= count_r))
    else $error("scan index past block count");

  // count moves by at most one entry per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(state_r) != S_INIT) |->
      (count_r == $past(count_r) || count_r == CNT_W'($past(count_r) + ONE_C)
       || count_r == CNT_W'($past(count_r) - ONE_C)))
    else $error("block count jumped");

  // a new result only leaves the result state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside result state");
`endif

endmodule
